/* sv/sha_pkg.sv */
`timescale 1ns / 1ps

package sha_pkg;

	// Block position at which the 64-bit length field starts.
	localparam logic [5:0] LEN_START_POS = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_NUM = 3'd7;
	localparam logic [7:0] PAD_MARK      = 8'h80;

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		BSEL_INPUT = 2'd0,
		BSEL_MARK  = 2'd1,
		BSEL_ZERO  = 2'd2,
		BSEL_LEN   = 2'd3
	} byte_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_FINISH = 5'b01000,
		ST_OUT    = 5'b10000
	} ctrl_state_t;

	typedef struct packed {
		logic      init;
		logic      shift_byte;
		byte_sel_t byte_sel;
		logic      count_bits;
		logic      start_block;
		logic      do_round;
		logic [5:0] round_idx;
		logic      finish_block;
		logic [2:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} dp_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] rnd_sum_a(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] rnd_sum_e(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sched_mix15(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sched_mix2(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* sv/sha_dp.sv */
`timescale 1ns / 1ps

module sha_dp import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  data_byte,
	output dp_stat_t    stat,
	output logic [31:0] digest
);

	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [511:0] blk_q;
	logic [5:0]   pos_q;
	logic [63:0]  bits_q;

	logic [7:0]  byte_in;
	logic [2:0]  len_sel;
	logic [31:0] w_t;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	// Length bytes go out most significant first at positions 56 to 63.
	assign len_sel = 3'd7 - pos_q[2:0];

	always_comb begin
		case (cmd.byte_sel)
			BSEL_INPUT: byte_in = data_byte;
			BSEL_MARK:  byte_in = PAD_MARK;
			BSEL_ZERO:  byte_in = 8'h00;
			BSEL_LEN:   byte_in = bits_q[{len_sel, 3'b000} +: 8];
			default:    byte_in = 8'h00;
		endcase
	end

	// The block register doubles as the rolling schedule: word 0 sits in the top bits.
	assign w_t   = blk_q[511:480];
	assign w_new = sched_mix2(blk_q[63:32]) + blk_q[223:192]
		+ sched_mix15(blk_q[479:448]) + blk_q[511:480];

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + rnd_sum_e(v_q[4]) + ch + K_TABLE[cmd.round_idx] + w_t;
	assign t2  = rnd_sum_a(v_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
			pos_q  <= '0;
			bits_q <= '0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= H_INIT[i];
				end
				bits_q <= '0;
				pos_q  <= '0;
			end else begin
				if (cmd.finish_block) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				if (cmd.shift_byte) begin
					pos_q <= pos_q + 6'd1;
				end
				if (cmd.count_bits) begin
					bits_q <= bits_q + 64'd8;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.do_round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.start_block) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.do_round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign stat.pos = pos_q;
	assign digest   = h_q[cmd.word_idx];

endmodule

/* sv/sha_ctrl.sv */
`timescale 1ns / 1ps

module sha_ctrl import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tuser,
	input  logic       s_tlast,
	input  logic       m_tready,
	input  dp_stat_t   stat,
	output logic       s_tready,
	output logic       m_tvalid,
	output logic       m_tlast,
	output logic [2:0] word_num,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  word_q;
	logic        pad_q;
	logic        mark_q;
	logic        len_phase_q;
	logic        len_done_q;

	logic      accept;
	logic      block_full;
	byte_sel_t pad_sel;

	assign accept     = s_tvalid && (state_q == ST_IDLE);
	assign block_full = (stat.pos == LAST_POS);

	always_comb begin
		if (!mark_q) begin
			pad_sel = BSEL_MARK;
		end else if (len_phase_q || (stat.pos == LEN_START_POS)) begin
			pad_sel = BSEL_LEN;
		end else begin
			pad_sel = BSEL_ZERO;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.byte_sel  = BSEL_INPUT;
		cmd.round_idx = rnd_q;
		cmd.word_idx  = word_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser) begin
					cmd.shift_byte  = 1'b1;
					cmd.count_bits  = 1'b1;
					cmd.start_block = block_full;
				end
			end
			ST_PAD: begin
				cmd.shift_byte  = 1'b1;
				cmd.byte_sel    = pad_sel;
				cmd.start_block = block_full;
			end
			ST_ROUND:  cmd.do_round     = 1'b1;
			ST_FINISH: cmd.finish_block = 1'b1;
			ST_OUT:    cmd.init         = m_tready && (word_q == LAST_WORD_NUM);
			default:   cmd.init         = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			word_q      <= '0;
			pad_q       <= 1'b0;
			mark_q      <= 1'b0;
			len_phase_q <= 1'b0;
			len_done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser && block_full) begin
							state_q <= ST_ROUND;
							pad_q   <= s_tlast;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
							pad_q   <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (pad_sel == BSEL_LEN) begin
						len_phase_q <= 1'b1;
					end
					if (block_full) begin
						state_q <= ST_ROUND;
						if (pad_sel == BSEL_LEN) begin
							len_done_q <= 1'b1;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (len_done_q) begin
						state_q <= ST_OUT;
						word_q  <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						word_q <= word_q + 3'd1;
						if (word_q == LAST_WORD_NUM) begin
							state_q     <= ST_IDLE;
							pad_q       <= 1'b0;
							mark_q      <= 1'b0;
							len_phase_q <= 1'b0;
							len_done_q  <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = (word_q == LAST_WORD_NUM);
	assign word_num = word_q;

endmodule

/* sv/sha256_message_hasher_top.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Signals                                | Beat contents
// ---------+-----------+----------------------------------------+---------------------------------
// s_axis   | in        | s_tvalid s_tready s_tdata s_tuser s_tlast | one message byte or an end mark
// m_axis   | out       | m_tvalid m_tready m_tdata m_tlast       | one digest word, eight per message
//
// The 64th byte of a block starts the single round unit: the round state runs the rounds,
// and a finish state then adds the round variables into the chained hash. After the end
// mark up to 72 padding bytes go in at one per cycle outside the compressions, with one or
// two compressions, and then eight beats leave, one per cycle while m_tready is high.
// s_tready is low while a block compresses, while padding runs and while the digest goes out.
// Reset is asynchronous and active low and loads the initial hash values.

module sha256_message_hasher_top import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // final_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
	output logic        m_tlast    // last_word
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] digest;
	logic [2:0]  word_num;

	// The controller sequences byte loading, padding, rounds and the digest beats.
	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.stat     (stat),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tlast  (m_tlast),
		.word_num (word_num),
		.cmd      (cmd)
	);

	// The datapath holds the block and schedule, the round variables and the chained hash.
	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (s_tdata),
		.stat      (stat),
		.digest    (digest)
	);

	assign m_tdata = {5'b00000, word_num, digest};

endmodule

/* sv/sha_port_chk.sv */
`timescale 1ns / 1ps

module sha_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// A stalled digest beat holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled digest beat changed");

	// Input is never taken while the digest goes out.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during digest output");

	// Digest words follow one another in order.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
		else $error("digest word number out of order");

	// The last beat carries word number seven and ends the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
		else $error("last flag does not match word number");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("output did not end after last word");

endmodule

bind sha256_message_hasher_top sha_port_chk u_port_chk (.*);
